// ----- src/smac_pkg.sv -----
`default_nettype none
package smac_pkg;

	// default geometry
	localparam int unsigned SMAC_STACK_DEPTH = 256;
	localparam int unsigned SMAC_WORD_BITS   = 32;

	// fixed port field widths
	localparam int unsigned CMD_BITS    = 3;
	localparam int unsigned STATUS_BITS = 3;
	localparam int unsigned FIELD_BITS  = 32;

	// opcodes
	localparam logic [CMD_BITS-1:0] OP_PUSH  = 3'd0;
	localparam logic [CMD_BITS-1:0] OP_ADD   = 3'd1;
	localparam logic [CMD_BITS-1:0] OP_SUB   = 3'd2;
	localparam logic [CMD_BITS-1:0] OP_MUL   = 3'd3;
	localparam logic [CMD_BITS-1:0] OP_DIV   = 3'd4;
	localparam logic [CMD_BITS-1:0] OP_EMIT  = 3'd5;
	localparam logic [CMD_BITS-1:0] OP_HALT  = 3'd6;
	localparam logic [CMD_BITS-1:0] OP_NONE  = 3'd7;

	// result status codes
	localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_PRINTED   = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_HALTED    = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 3'd4;
	localparam logic [STATUS_BITS-1:0] ST_DIVZERO   = 3'd5;
	localparam logic [STATUS_BITS-1:0] ST_IGNORED   = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic                   load_in;
		logic                   push;
		logic                   rd_top;
		logic                   rd_second;
		logic                   ld_b;
		logic                   ld_a;
		logic                   iter_start;
		logic                   iter_step;
		logic                   write_result;
		logic                   pop;
		logic                   out_load;
		logic [STATUS_BITS-1:0] out_status;
	} smac_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_BITS-1:0] cmd;
		logic                empty;
		logic                below_two;
		logic                full;
		logic                b_zero;
		logic                iter_last;
	} smac_stat_t;

endpackage
`default_nettype wire

// ----- src/stack_machine_alu_core.sv -----
// push, halt, ignored and error-on-decode items go from decode straight to the output register; print reads the top,
// add and sub read two words and write back, mul and div also run the shift unit before the write-back
// one item in flight; next word taken in the cycle after the result is loaded
// mul and div run on a shared shift unit at one bit per cycle (shift-add, restoring divide)
// arst_n clears the stack count, the halt flag, the controller and the output valid;
// stack memory is not cleared, entries are only read after being written
`default_nettype none
module stack_machine_alu_core #(
	parameter int STACK_DEPTH = smac_pkg::SMAC_STACK_DEPTH,
	parameter int WORD_BITS   = smac_pkg::SMAC_WORD_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// instruction word
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [smac_pkg::CMD_BITS-1:0]          cmd,
	input  wire logic signed [smac_pkg::FIELD_BITS-1:0] operand,
	// result word
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [smac_pkg::STATUS_BITS-1:0]            status,
	output logic signed [smac_pkg::FIELD_BITS-1:0]      value
);

	// controller/datapath interface
	smac_pkg::smac_cmd_t  ctl;
	smac_pkg::smac_stat_t st;

	// stack memory port
	logic                         ram_we;
	logic                         ram_re;
	logic [$clog2(STACK_DEPTH)-1:0] ram_addr;
	logic [WORD_BITS-1:0]         ram_wdata;
	logic [WORD_BITS-1:0]         ram_rdata;

	// sequencer: decode, stack checks, operand fetch, iteration, result handoff
	smac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd_o     (ctl)
	);

	// stack pointer, operand registers, shift unit and output register
	smac_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.WORD_BITS   (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operand   (operand),
		.ctl       (ctl),
		.st        (st),
		.status    (status),
		.value     (value),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	// data stack, one access per cycle
	smac_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	// one item at a time: an accepted word closes the input until its result is loaded into the output register
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// the stack port never reads and writes in the same cycle
	a_ram_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("stack read and write collide");

	// value is only nonzero for a printed word
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != smac_pkg::ST_PRINTED |-> value == '0)
		else $error("nonzero value on a non-print result");

	// a new result is only loaded while the input side is closed
	a_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !in_ready)
		else $error("result loaded while idle");

	// a push never happens on a full stack
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !st.full)
		else $error("push on full stack");
`endif

endmodule
`default_nettype wire

// ----- src/smac_ram.sv -----
`default_nettype none
module smac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- src/smac_ctrl.sv -----
`default_nettype none
module smac_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire smac_pkg::smac_stat_t st,
	output smac_pkg::smac_cmd_t     cmd_o
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RD_B,
		S_RD_A,
		S_EXEC,
		S_ITER,
		S_WB,
		S_OUT
	} state_t;

	state_t                               state_q, state_d;
	logic                                 stopped_q, stopped_d;
	logic [smac_pkg::STATUS_BITS-1:0]     res_q, res_d;
	logic                                 out_valid_q, out_valid_d;

	always_comb begin
		cmd_o     = '0;
		state_d   = state_q;
		stopped_d = stopped_q;
		res_d     = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_o.load_in = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_OUT;
				if (stopped_q || st.cmd == smac_pkg::OP_NONE) begin
					res_d = smac_pkg::ST_IGNORED;
				end else begin
					unique case (st.cmd) inside
						smac_pkg::OP_PUSH: begin
							if (st.full) begin
								res_d     = smac_pkg::ST_OVERFLOW;
								stopped_d = 1'b1;
							end else begin
								cmd_o.push = 1'b1;
								res_d      = smac_pkg::ST_OK;
							end
						end
						smac_pkg::OP_EMIT: begin
							if (st.empty) begin
								res_d     = smac_pkg::ST_UNDERFLOW;
								stopped_d = 1'b1;
							end else begin
								cmd_o.rd_top = 1'b1;
								state_d      = S_RD_B;
							end
						end
						smac_pkg::OP_HALT: begin
							res_d     = smac_pkg::ST_HALTED;
							stopped_d = 1'b1;
						end
						default: begin
							// add, sub, mul, div
							if (st.below_two) begin
								res_d     = smac_pkg::ST_UNDERFLOW;
								stopped_d = 1'b1;
							end else begin
								cmd_o.rd_top = 1'b1;
								state_d      = S_RD_B;
							end
						end
					endcase
				end
			end
			S_RD_B: begin
				cmd_o.ld_b = 1'b1;
				if (st.cmd == smac_pkg::OP_EMIT) begin
					cmd_o.pop = 1'b1;
					res_d     = smac_pkg::ST_PRINTED;
					state_d   = S_OUT;
				end else begin
					cmd_o.rd_second = 1'b1;
					state_d         = S_RD_A;
				end
			end
			S_RD_A: begin
				cmd_o.ld_a = 1'b1;
				state_d    = S_EXEC;
			end
			S_EXEC: begin
				if (st.cmd == smac_pkg::OP_DIV && st.b_zero) begin
					res_d     = smac_pkg::ST_DIVZERO;
					stopped_d = 1'b1;
					state_d   = S_OUT;
				end else if (st.cmd == smac_pkg::OP_ADD || st.cmd == smac_pkg::OP_SUB) begin
					cmd_o.write_result = 1'b1;
					res_d              = smac_pkg::ST_OK;
					state_d            = S_OUT;
				end else begin
					cmd_o.iter_start = 1'b1;
					state_d          = S_ITER;
				end
			end
			S_ITER: begin
				cmd_o.iter_step = 1'b1;
				if (st.iter_last) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				cmd_o.write_result = 1'b1;
				res_d              = smac_pkg::ST_OK;
				state_d            = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd_o.out_load = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd_o.out_status = res_q;

		if (cmd_o.out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stopped_q   <= 1'b0;
			res_q       <= smac_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			stopped_q   <= stopped_d;
			res_q       <= res_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- src/smac_dp.sv -----
`default_nettype none
module smac_dp #(
	parameter int STACK_DEPTH = smac_pkg::SMAC_STACK_DEPTH,
	parameter int WORD_BITS   = smac_pkg::SMAC_WORD_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [smac_pkg::CMD_BITS-1:0]       cmd,
	input  wire logic signed [smac_pkg::FIELD_BITS-1:0] operand,
	input  wire smac_pkg::smac_cmd_t                 ctl,
	output smac_pkg::smac_stat_t                     st,
	output logic [smac_pkg::STATUS_BITS-1:0]         status,
	output logic signed [smac_pkg::FIELD_BITS-1:0]   value,
	output logic                                     ram_we,
	output logic                                     ram_re,
	output logic [$clog2(STACK_DEPTH)-1:0]           ram_addr,
	output logic [WORD_BITS-1:0]                     ram_wdata,
	input  wire logic [WORD_BITS-1:0]                ram_rdata
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(WORD_BITS + 1);
	localparam int FB = smac_pkg::FIELD_BITS;

	logic [smac_pkg::CMD_BITS-1:0] cmd_q;
	logic [WORD_BITS-1:0]          operand_q;
	logic [CW-1:0]                 count_q;
	logic [WORD_BITS-1:0]          a_q, b_q, acc_q;
	logic [IW-1:0]                 it_q;
	logic                          neg_q;
	logic [smac_pkg::STATUS_BITS-1:0] status_q;
	logic [FB-1:0]                 value_q;

	logic [WORD_BITS-1:0] op_ext, result, a_neg, b_neg;
	logic [FB-1:0]        print_val;
	logic [CW-1:0]        count_m1, count_m2;
	logic [WORD_BITS:0]   rem_sh, rem_diff;

	// operand sign-extended or wrapped to the word size
	if (WORD_BITS > FB) begin : g_op_wide
		assign op_ext = {{(WORD_BITS-FB){operand[FB-1]}}, operand};
	end else begin : g_op_narrow
		assign op_ext = operand[WORD_BITS-1:0];
	end

	// printed word: low field bits, zero-filled for narrow words
	if (WORD_BITS >= FB) begin : g_pv_wide
		assign print_val = b_q[FB-1:0];
	end else begin : g_pv_narrow
		assign print_val = {{(FB-WORD_BITS){1'b0}}, b_q};
	end

	assign count_m1 = count_q - CW'(1);
	assign count_m2 = count_q - CW'(2);
	assign a_neg    = ~a_q + WORD_BITS'(1);
	assign b_neg    = ~b_q + WORD_BITS'(1);

	// restoring divide step: remainder in acc_q, dividend/quotient in a_q
	assign rem_sh   = {acc_q, a_q[WORD_BITS-1]};
	assign rem_diff = rem_sh - {1'b0, b_q};

	always_comb begin
		case (cmd_q)
			smac_pkg::OP_ADD: result = a_q + b_q;
			smac_pkg::OP_SUB: result = a_q - b_q;
			smac_pkg::OP_MUL: result = acc_q;
			default:          result = neg_q ? a_neg : a_q;
		endcase
	end

	assign ram_we    = ctl.push | ctl.write_result;
	assign ram_re    = ctl.rd_top | ctl.rd_second;
	assign ram_wdata = ctl.push ? operand_q : result;

	always_comb begin
		if (ctl.push) begin
			ram_addr = count_q[AW-1:0];
		end else if (ctl.rd_top) begin
			ram_addr = count_m1[AW-1:0];
		end else begin
			ram_addr = count_m2[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.pop || ctl.write_result) begin
			count_q <= count_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q     <= cmd;
			operand_q <= op_ext;
		end
		if (ctl.ld_b) begin
			b_q <= ram_rdata;
		end
		if (ctl.ld_a) begin
			a_q <= ram_rdata;
		end
		if (ctl.iter_start) begin
			acc_q <= '0;
			it_q  <= IW'(WORD_BITS);
			neg_q <= a_q[WORD_BITS-1] ^ b_q[WORD_BITS-1];
			if (cmd_q == smac_pkg::OP_DIV) begin
				a_q <= a_q[WORD_BITS-1] ? a_neg : a_q;
				b_q <= b_q[WORD_BITS-1] ? b_neg : b_q;
			end
		end
		if (ctl.iter_step) begin
			it_q <= it_q - IW'(1);
			if (cmd_q == smac_pkg::OP_MUL) begin
				// shift-add, wraps to the word size
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end else if (!rem_diff[WORD_BITS]) begin
				acc_q <= rem_diff[WORD_BITS-1:0];
				a_q   <= {a_q[WORD_BITS-2:0], 1'b1};
			end else begin
				acc_q <= rem_sh[WORD_BITS-1:0];
				a_q   <= {a_q[WORD_BITS-2:0], 1'b0};
			end
		end
		if (ctl.out_load) begin
			status_q <= ctl.out_status;
			value_q  <= (ctl.out_status == smac_pkg::ST_PRINTED) ? print_val : '0;
		end
	end

	assign st.cmd       = cmd_q;
	assign st.empty     = (count_q == '0);
	assign st.below_two = (count_q < CW'(2));
	assign st.full      = (count_q >= CW'(STACK_DEPTH));
	assign st.b_zero    = (b_q == '0);
	assign st.iter_last = (it_q == IW'(1));

	assign status = status_q;
	assign value  = value_q;

endmodule
`default_nettype wire
